>>> src/dkt_pkg.sv
// ----------------------------------------------------------------------------
// dkt_pkg: shared types and constants for the device key table
// Request and response payloads, opcodes, sequencer states and field widths.
// ----------------------------------------------------------------------------
package dkt_pkg;

	localparam int ADDR_W          = 32;
	localparam int KEY_W           = 64;
	localparam int SLOT_W          = 3;
	localparam int TABLE_DEPTH_DEF = 8;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_INSERT = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		op_t                 op;
		logic [ADDR_W-1:0]   device_address;
		logic [KEY_W-1:0]    key_high;
		logic [KEY_W-1:0]    key_low;
	} req_t;

	typedef struct packed {
		logic                found;
		logic [SLOT_W-1:0]   slot_index;
		logic [KEY_W-1:0]    result_key_high;
		logic [KEY_W-1:0]    result_key_low;
		logic                evicted;
	} rsp_t;

endpackage

>>> src/dkt_chan_if.sv
// ----------------------------------------------------------------------------
// dkt_chan_if: valid/ready channel
// Carries one payload of type T per request.
// ----------------------------------------------------------------------------
interface dkt_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> src/dkt_ram.sv
// ----------------------------------------------------------------------------
// dkt_ram: simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dkt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> src/device_key_table.sv
// ----------------------------------------------------------------------------
// device_key_table: associative device address / key table
// Lookup, replace-on-insert and oldest-first eviction over TABLE_DEPTH slots.
// ----------------------------------------------------------------------------
// Each request is handled on its own. A request with address zero skips the
// scan and goes straight to the result stage. A lookup scans the slots in
// order, one per cycle through the address RAM read port, and stops at the
// hit or after the last slot. An insert with a nonzero address always scans
// every slot. The next request is only taken back in the idle state. The
// result sits in an output register, so the next request is accepted while
// it waits to be taken; a new result is only loaded once the previous one is
// gone. No clearing pass is needed after reset: per-slot occupancy flags live
// in flip-flops.
//
// Slot order is kept as a ring over the physical RAM rows: logical slot s is
// row (base + s) mod TABLE_DEPTH. Eviction drops logical slot 0 by writing the
// new entry into row base and advancing base, so the shift-down is free.
// ----------------------------------------------------------------------------
module device_key_table #(
	parameter int TABLE_DEPTH = dkt_pkg::TABLE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	dkt_chan_if.sink     req,
	dkt_chan_if.source   rsp
);
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int KW = 2 * dkt_pkg::KEY_W;
	localparam logic [IW:0]   DEPTH_X  = (IW + 1)'(TABLE_DEPTH);
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(TABLE_DEPTH);

	// logical slot -> physical RAM row
	function automatic logic [IW-1:0] to_phys(input logic [IW-1:0] b,
	                                         input logic [IW-1:0] l);
		logic [IW:0] sum;
		sum = {1'b0, b} + {1'b0, l};
		if (sum >= DEPTH_X) begin
			sum = sum - DEPTH_X;
		end
		return sum[IW-1:0];
	endfunction

	// logical slot -> 3-bit result field (low bits)
	function automatic logic [dkt_pkg::SLOT_W-1:0] to_slot(input logic [IW-1:0] l);
		logic [IW+dkt_pkg::SLOT_W-1:0] wide;
		wide = {{dkt_pkg::SLOT_W{1'b0}}, l};
		return wide[dkt_pkg::SLOT_W-1:0];
	endfunction

	dkt_pkg::state_t state_q, state_d;

	// request being worked on
	dkt_pkg::op_t                op_q;
	logic [dkt_pkg::ADDR_W-1:0]  addr_q;
	logic [dkt_pkg::KEY_W-1:0]   kh_q;
	logic [dkt_pkg::KEY_W-1:0]   kl_q;

	// scan pipeline
	logic [CW-1:0]   iss_q;
	logic            rd_v_s1;
	logic [IW-1:0]   rd_log_s1;
	logic [IW-1:0]   rd_phys_s1;

	// table bookkeeping
	logic [IW-1:0]          base_q;
	logic [TABLE_DEPTH-1:0] occ_q;
	logic [TABLE_DEPTH-1:0] occ_d;

	// scan findings
	logic            match_v_q;
	logic [IW-1:0]   match_phys_q;
	logic            cand_v_q;
	logic [IW-1:0]   cand_log_q;
	logic [IW-1:0]   cand_phys_q;
	logic            lk_found_q;
	logic [IW-1:0]   lk_log_q;
	logic [dkt_pkg::KEY_W-1:0] lk_kh_q;
	logic [dkt_pkg::KEY_W-1:0] lk_kl_q;

	// output register
	logic            rsp_v_q;
	dkt_pkg::rsp_t   rsp_q, rsp_d;

	// control
	logic            req_ready;
	logic            issue_en;
	logic            finish_go;
	logic            accept;
	logic            scan_v;
	logic            hit;
	logic            cand;
	logic            last;
	logic            scan_done;
	logic            ins_go;
	logic            addr_nz;
	logic [IW-1:0]   iss_phys;
	logic [IW-1:0]   tgt_phys;
	logic [IW-1:0]   tgt_log;

	// RAM read data
	logic [dkt_pkg::ADDR_W-1:0] addr_rd;
	logic [KW-1:0]              key_rd;

	assign accept   = req.valid && req_ready;
	assign addr_nz  = (addr_q != '0);
	assign iss_phys = to_phys(base_q, iss_q[IW-1:0]);

	// data returned for the row issued last cycle
	assign scan_v = rd_v_s1 && (state_q == dkt_pkg::ST_SCAN);
	assign hit    = scan_v && occ_q[rd_phys_s1] && (addr_rd == addr_q);
	// first free slot after clearing the duplicate: empty, or the duplicate itself
	assign cand   = scan_v && (!occ_q[rd_phys_s1] || hit);
	assign last   = scan_v && (rd_log_s1 == LAST_IDX);
	assign scan_done = last || (hit && (op_q == dkt_pkg::OP_LOOKUP));

	// insert target: first free slot, else evict into the ring head
	assign tgt_phys = cand_v_q ? cand_phys_q : base_q;
	assign tgt_log  = cand_v_q ? cand_log_q  : LAST_IDX;
	assign ins_go   = finish_go && (op_q == dkt_pkg::OP_INSERT) && addr_nz;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dkt_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (req.data.device_address == '0) ?
						dkt_pkg::ST_FINISH : dkt_pkg::ST_SCAN;
				end
			end
			dkt_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = dkt_pkg::ST_FINISH;
				end
			end
			dkt_pkg::ST_FINISH: begin
				if (finish_go) begin
					state_d = dkt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dkt_pkg::ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		req_ready = 1'b0;
		issue_en  = 1'b0;
		finish_go = 1'b0;
		case (state_q)
			dkt_pkg::ST_IDLE: begin
				req_ready = 1'b1;
			end
			dkt_pkg::ST_SCAN: begin
				issue_en = (iss_q < DEPTH_C);
			end
			dkt_pkg::ST_FINISH: begin
				finish_go = !rsp_v_q || rsp.ready;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dkt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.data.op;
			addr_q <= req.data.device_address;
			kh_q   <= req.data.key_high;
			kl_q   <= req.data.key_low;
		end
	end

	// scan counter and read tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q   <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= issue_en;
			if (accept) begin
				iss_q <= '0;
			end else if (issue_en) begin
				iss_q <= iss_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue_en) begin
			rd_log_s1  <= iss_q[IW-1:0];
			rd_phys_s1 <= iss_phys;
		end
	end

	// scan findings (flags)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_v_q  <= 1'b0;
			cand_v_q   <= 1'b0;
			lk_found_q <= 1'b0;
		end else if (accept) begin
			match_v_q  <= 1'b0;
			cand_v_q   <= 1'b0;
			lk_found_q <= 1'b0;
		end else begin
			if (hit) begin
				match_v_q <= 1'b1;
			end
			if (cand) begin
				cand_v_q <= 1'b1;
			end
			if (hit && (op_q == dkt_pkg::OP_LOOKUP)) begin
				lk_found_q <= 1'b1;
			end
		end
	end

	// scan findings (payload); addresses are unique, so a hit is the only one
	always_ff @(posedge clk) begin
		if (hit) begin
			match_phys_q <= rd_phys_s1;
			lk_log_q     <= rd_log_s1;
			lk_kh_q      <= key_rd[KW-1:dkt_pkg::KEY_W];
			lk_kl_q      <= key_rd[dkt_pkg::KEY_W-1:0];
		end
		if (cand && !cand_v_q) begin
			cand_log_q  <= rd_log_s1;
			cand_phys_q <= rd_phys_s1;
		end
	end

	// occupancy after an insert: clear the duplicate, then mark the target
	always_comb begin
		occ_d = occ_q;
		if (match_v_q) begin
			occ_d[match_phys_q] = 1'b0;
		end
		occ_d[tgt_phys] = 1'b1;
	end

	// occupancy and ring head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			base_q <= '0;
		end else if (ins_go) begin
			occ_q <= occ_d;
			if (!cand_v_q) begin
				base_q <= (base_q == LAST_IDX) ? '0 : base_q + 1'b1;
			end
		end
	end

	// result assembly
	always_comb begin
		rsp_d = '0;
		if (op_q == dkt_pkg::OP_INSERT) begin
			if (addr_nz) begin
				rsp_d.found      = match_v_q;
				rsp_d.slot_index = to_slot(tgt_log);
				rsp_d.evicted    = !cand_v_q;
			end
		end else if (lk_found_q) begin
			rsp_d.found           = 1'b1;
			rsp_d.slot_index      = to_slot(lk_log_q);
			rsp_d.result_key_high = lk_kh_q;
			rsp_d.result_key_low  = lk_kl_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (finish_go) begin
			rsp_v_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_go) begin
			rsp_q <= rsp_d;
		end
	end

	assign req.ready = req_ready;
	assign rsp.valid = rsp_v_q;
	assign rsp.data  = rsp_q;

	// address store: read during the scan, written on insert
	dkt_ram #(
		.WIDTH (dkt_pkg::ADDR_W),
		.DEPTH (TABLE_DEPTH)
	) u_addr_ram (
		.clk   (clk),
		.we    (ins_go),
		.waddr (tgt_phys),
		.wdata (addr_q),
		.re    (issue_en),
		.raddr (iss_phys),
		.rdata (addr_rd)
	);

	// key store: read alongside the address so a hit has its key at once
	dkt_ram #(
		.WIDTH (KW),
		.DEPTH (TABLE_DEPTH)
	) u_key_ram (
		.clk   (clk),
		.we    (ins_go),
		.waddr (tgt_phys),
		.wdata ({kh_q, kl_q}),
		.re    (issue_en),
		.raddr (iss_phys),
		.rdata (key_rd)
	);
endmodule

>>> src/dkt_checker.sv
// ----------------------------------------------------------------------------
// dkt_checker: port-level checks for the device key table
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
module dkt_checker #(
	parameter int TABLE_DEPTH = dkt_pkg::TABLE_DEPTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input dkt_pkg::rsp_t rsp_data
);
	localparam logic [dkt_pkg::SLOT_W-1:0] LAST_SLOT =
		dkt_pkg::SLOT_W'((TABLE_DEPTH - 1) % (1 << dkt_pkg::SLOT_W));

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response changed while stalled");

	// one request at a time: busy right after a request is taken
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one in progress");

	// a new response only appears after the block was busy
	a_rsp_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("response without work");

	// eviction: last slot, no duplicate cleared, no key returned
	a_evict_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.evicted |->
			rsp_data.slot_index == LAST_SLOT && !rsp_data.found &&
			rsp_data.result_key_high == '0 && rsp_data.result_key_low == '0)
		else $error("malformed eviction response");
endmodule

bind device_key_table dkt_checker #(
	.TABLE_DEPTH (TABLE_DEPTH)
) u_dkt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
